// ===== src/set_assoc_cache_tag_controller_macros.svh =====
// Assertion macros shared by the cache tag controller RTL.
// No dependencies; included by the files that carry concurrent assertions.
`ifndef SET_ASSOC_CACHE_TAG_CONTROLLER_MACROS_SVH
`define SET_ASSOC_CACHE_TAG_CONTROLLER_MACROS_SVH

`ifndef ASSERT_OFF
`define SACC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sacc: implication check failed");
`define SACC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sacc: next-cycle check failed");
`else
`define SACC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SACC_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== src/sacc_pkg.sv =====
// Shared types and constants of the cache tag controller.
// No dependencies; imported by every module of the block but sacc_ram.
package sacc_pkg;

    localparam int NUM_SETS       = 64;
    localparam int NUM_WAYS       = 4;
    localparam int LONGS_PER_LINE = 4;
    localparam int TAG_W          = 22;
    localparam int SET_W          = 6;
    localparam int WAY_W          = 2;
    localparam int CNT_W          = 9;
    localparam int ADDR_W         = 32;
    localparam int TAG_LSB        = 10;
    localparam int SET_LSB        = 4;
    localparam int LONG_LSB       = 2;
    localparam int PADDR_W        = 3;
    localparam int PDATA_W        = 32;

    localparam logic [1:0] PS_NONE = 2'd0;
    localparam logic [1:0] PS_4K   = 2'd1;
    localparam logic [1:0] PS_8K   = 2'd2;

    localparam logic [1:0] LS_INVALID = 2'd0;
    localparam logic [1:0] LS_CLEAN   = 2'd1;
    localparam logic [1:0] LS_DIRTY   = 2'd2;

    typedef enum logic [3:0] {
        OP_PROBE      = 4'd0,
        OP_TICK       = 4'd1,
        OP_FILL       = 4'd2,
        OP_MARK_DIRTY = 4'd3,
        OP_INV_LINE   = 4'd4,
        OP_INV_PAGE   = 4'd5,
        OP_INV_ALL    = 4'd6,
        OP_PUSH_LINE  = 4'd7,
        OP_PUSH_PAGE  = 4'd8,
        OP_PUSH_ALL   = 4'd9
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_WALK,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic [NUM_WAYS-1:0][TAG_W-1:0]          tag;
        logic [NUM_WAYS-1:0][LONGS_PER_LINE-1:0] dirty;
    } set_entry_t;

    typedef struct packed {
        logic                      hit;
        logic [WAY_W-1:0]          hit_way;
        logic [LONGS_PER_LINE-1:0] hit_dirty;
        logic [WAY_W-1:0]          victim;
        logic [NUM_WAYS-1:0]       drop_mask;
        logic [2:0]                drop_count;
        logic [2:0]                dirty_count;
    } look_t;

endpackage

// ===== src/set_assoc_cache_tag_controller.sv =====
// Tag and state store of a 64-set, 4-way cache: control sequencer and state.
// Depends on sacc_pkg, sacc_ram, sacc_lookup, sacc_cfg and the macros header.
//
// Usage
//   Request channel: opcode, address, way, fill_dirty_mask, page_size, taken on
//   a rising edge with in_valid high and in_stall low. One result per request
//   on the result channel, taken with out_valid high and out_stall low.
//   Line operations (probe, tick, fill, mark dirty, line invalidate/push) read
//   the set into the RAM's read register; fill writes it back, as does mark
//   dirty while dirty_state_enable is 1; line invalidate/push clear the valid
//   bit of a hit; the result goes to the output register. Page and all
//   operations walk the 64 sets one per cycle through the RAM read port.
//   in_stall is high while a request is in progress; the next request is taken
//   even while a result waits in the output register. A stalled result holds;
//   the sequencer holds the finishing step until the output register is free,
//   so a stall still on when the next request finishes backs up into in_stall.
//   Reset clears all valid bits, the replacement counter and the output
//   register at once; no clearing pass. dirty_state_enable resets to 1. Config
//   writes go through the APB port; the user makes them while the block is idle.
`include "set_assoc_cache_tag_controller_macros.svh"

module set_assoc_cache_tag_controller (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [sacc_pkg::PADDR_W-1:0]          paddr,
    input  logic [sacc_pkg::PDATA_W-1:0]          pwdata,
    output logic [sacc_pkg::PDATA_W-1:0]          prdata,
    output logic                                  pready,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [3:0]                            opcode,
    input  logic [sacc_pkg::ADDR_W-1:0]           address,
    input  logic [sacc_pkg::WAY_W-1:0]            way,
    input  logic [sacc_pkg::LONGS_PER_LINE-1:0]   fill_dirty_mask,
    input  logic [1:0]                            page_size,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic                                  hit,
    output logic [sacc_pkg::WAY_W-1:0]            hit_way,
    output logic [sacc_pkg::WAY_W-1:0]            victim_way,
    output logic [1:0]                            line_state,
    output logic [sacc_pkg::LONGS_PER_LINE-1:0]   writeback_mask,
    output logic [sacc_pkg::CNT_W-1:0]            lines_touched,
    output logic [sacc_pkg::CNT_W-1:0]            dirty_dropped
);
    import sacc_pkg::*;

    localparam logic [SET_W-1:0] LAST_SET = SET_W'(NUM_SETS - 1);

    state_t                    state_reg, state_next;
    op_t                       op_reg;
    logic [ADDR_W-1:0]         addr_reg;
    logic [WAY_W-1:0]          way_reg;
    logic [LONGS_PER_LINE-1:0] fmask_reg;
    logic [1:0]                ps_reg;
    logic [SET_W-1:0]          walk_idx_reg, walk_idx_next;
    logic [CNT_W-1:0]          touched_reg, touched_next;
    logic [CNT_W-1:0]          dcount_reg, dcount_next;
    logic [WAY_W-1:0]          ctr_reg, ctr_next;
    logic [NUM_WAYS-1:0]       valid_reg [NUM_SETS];

    logic                      out_valid_reg;
    logic                      hit_reg;
    logic [WAY_W-1:0]          hit_way_reg;
    logic [WAY_W-1:0]          victim_reg;
    logic [1:0]                lstate_reg;
    logic [LONGS_PER_LINE-1:0] wb_reg;
    logic [CNT_W-1:0]          touched_out_reg;
    logic [CNT_W-1:0]          dirty_out_reg;

    logic                      res_hit;
    logic [WAY_W-1:0]          res_hit_way;
    logic [WAY_W-1:0]          res_victim;
    logic [1:0]                res_lstate;
    logic [LONGS_PER_LINE-1:0] res_wb;
    logic [CNT_W-1:0]          res_touched;
    logic [CNT_W-1:0]          res_dirty;
    logic                      load_out;

    logic                      accept;
    logic                      out_free;
    logic                      walk_op;
    logic                      dse;

    logic                      ram_we;
    logic                      ram_re;
    logic [SET_W-1:0]          ram_raddr;
    logic [$bits(set_entry_t)-1:0] ram_rdata;
    set_entry_t                entry;
    set_entry_t                wentry;

    logic [SET_W-1:0]          cur_set;
    logic                      whole;
    look_t                     look;

    logic                      vld_we;
    logic [NUM_WAYS-1:0]       vld_set_mask;
    logic [NUM_WAYS-1:0]       vld_clr_mask;

    sacc_cfg u_cfg (
        .clk                (clk),
        .rst_n              (rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .dirty_state_enable (dse)
    );

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    assign walk_op = (opcode == OP_INV_PAGE) || (opcode == OP_INV_ALL) ||
                     (opcode == OP_PUSH_PAGE) || (opcode == OP_PUSH_ALL);

    // read the request's set at accept (set 0 for a walk), then the next set
    // on each walk step
    assign ram_re    = accept || ((state_reg == ST_WALK) && (walk_idx_reg != LAST_SET));
    assign ram_raddr = accept ? (walk_op ? '0 : address[TAG_LSB-1:SET_LSB]) :
                                walk_idx_reg + 1'b1;

    // writes land before the next request can be taken, so a read
    // never overlaps a pending write to the same set
    sacc_ram #(
        .WIDTH ($bits(set_entry_t)),
        .DEPTH (NUM_SETS)
    ) u_tag_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (addr_reg[TAG_LSB-1:SET_LSB]),
        .wdata (wentry),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign entry   = set_entry_t'(ram_rdata);
    assign cur_set = (state_reg == ST_WALK) ? walk_idx_reg : addr_reg[TAG_LSB-1:SET_LSB];
    assign whole   = (op_reg == OP_INV_ALL) || (op_reg == OP_PUSH_ALL);

    sacc_lookup u_lookup (
        .entry     (entry),
        .valid     (valid_reg[cur_set]),
        .address   (addr_reg),
        .page_size (ps_reg),
        .whole     (whole),
        .counter   (ctr_reg),
        .res       (look)
    );

    always_comb
    begin
        state_next    = state_reg;
        walk_idx_next = walk_idx_reg;
        touched_next  = touched_reg;
        dcount_next   = dcount_reg;
        ctr_next      = ctr_reg;
        ram_we        = 1'b0;
        wentry        = entry;
        vld_we        = 1'b0;
        vld_set_mask  = '0;
        vld_clr_mask  = '0;
        load_out      = 1'b0;
        res_hit       = 1'b0;
        res_hit_way   = '0;
        res_victim    = '0;
        res_lstate    = LS_INVALID;
        res_wb        = '0;
        res_touched   = '0;
        res_dirty     = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next    = walk_op ? ST_WALK : ST_LOOK;
                    walk_idx_next = '0;
                    touched_next  = '0;
                    dcount_next   = '0;
                end
            end
            ST_LOOK:
            begin
                // hold every side effect until the result can be registered
                if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                    unique case (op_reg)
                        OP_PROBE:
                        begin
                            res_hit     = look.hit;
                            res_hit_way = look.hit_way;
                            res_victim  = look.victim;
                            if (look.hit)
                            begin
                                res_lstate = (|look.hit_dirty) ? LS_DIRTY : LS_CLEAN;
                            end
                        end
                        OP_TICK:
                        begin
                            ctr_next = ctr_reg + 1'b1;
                        end
                        OP_FILL:
                        begin
                            ram_we                = 1'b1;
                            wentry.tag[way_reg]   = addr_reg[ADDR_W-1:TAG_LSB];
                            wentry.dirty[way_reg] = dse ? fmask_reg : '0;
                            vld_we                = 1'b1;
                            vld_set_mask[way_reg] = 1'b1;
                        end
                        OP_MARK_DIRTY:
                        begin
                            ram_we                = dse;
                            wentry.dirty[way_reg] = entry.dirty[way_reg] |
                                (LONGS_PER_LINE'(1) << addr_reg[SET_LSB-1:LONG_LSB]);
                        end
                        OP_INV_LINE, OP_PUSH_LINE:
                        begin
                            if (look.hit)
                            begin
                                vld_we                     = 1'b1;
                                vld_clr_mask[look.hit_way] = 1'b1;
                                res_touched                = CNT_W'(1);
                                if (op_reg == OP_PUSH_LINE)
                                begin
                                    res_wb = look.hit_dirty;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                // dirty data of dropped lines is left in the RAM; it is
                // never seen again without a fill overwriting it
                vld_we        = 1'b1;
                vld_clr_mask  = look.drop_mask;
                touched_next  = touched_reg + CNT_W'(look.drop_count);
                dcount_next   = dcount_reg + CNT_W'(look.dirty_count);
                walk_idx_next = walk_idx_reg + 1'b1;
                if (walk_idx_reg == LAST_SET)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    load_out    = 1'b1;
                    state_next  = ST_IDLE;
                    res_touched = touched_reg;
                    if ((op_reg == OP_PUSH_PAGE) || (op_reg == OP_PUSH_ALL))
                    begin
                        res_dirty = dcount_reg;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            walk_idx_reg  <= '0;
            touched_reg   <= '0;
            dcount_reg    <= '0;
            ctr_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int s = 0; s < NUM_SETS; s++)
            begin
                valid_reg[s] <= '0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            walk_idx_reg <= walk_idx_next;
            touched_reg  <= touched_next;
            dcount_reg   <= dcount_next;
            ctr_reg      <= ctr_next;
            if (vld_we)
            begin
                valid_reg[cur_set] <= (valid_reg[cur_set] & ~vld_clr_mask) | vld_set_mask;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= op_t'(opcode);
            addr_reg  <= address;
            way_reg   <= way;
            fmask_reg <= fill_dirty_mask;
            ps_reg    <= page_size;
        end
        if (load_out)
        begin
            hit_reg         <= res_hit;
            hit_way_reg     <= res_hit_way;
            victim_reg      <= res_victim;
            lstate_reg      <= res_lstate;
            wb_reg          <= res_wb;
            touched_out_reg <= res_touched;
            dirty_out_reg   <= res_dirty;
        end
    end

    assign out_valid      = out_valid_reg;
    assign hit            = hit_reg;
    assign hit_way        = hit_way_reg;
    assign victim_way     = victim_reg;
    assign line_state     = lstate_reg;
    assign writeback_mask = wb_reg;
    assign lines_touched  = touched_out_reg;
    assign dirty_dropped  = dirty_out_reg;

    `SACC_ASSERT_IMP(a_ram_we_in_look, clk, rst_n, ram_we, (state_reg == ST_LOOK) && out_free)
    `SACC_ASSERT_NXT(a_walk_ends, clk, rst_n, (state_reg == ST_WALK) && (walk_idx_reg == LAST_SET), state_reg == ST_FIN)
    `SACC_ASSERT_IMP(a_dirty_le_touched, clk, rst_n, out_valid_reg, dirty_out_reg <= touched_out_reg)
    `SACC_ASSERT_IMP(a_hit_has_state, clk, rst_n, out_valid_reg && hit_reg, lstate_reg != LS_INVALID)

endmodule

// ===== src/sacc_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies; holds the per-set tag and dirty words.
module sacc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/sacc_lookup.sv =====
// Set compare logic: tag match, victim choice and page match over the four ways.
// Depends on sacc_pkg for the set word and result types.
module sacc_lookup (
    input  sacc_pkg::set_entry_t                 entry,
    input  logic [sacc_pkg::NUM_WAYS-1:0]        valid,
    input  logic [sacc_pkg::ADDR_W-1:0]          address,
    input  logic [1:0]                           page_size,
    input  logic                                 whole,
    input  logic [sacc_pkg::WAY_W-1:0]           counter,
    output sacc_pkg::look_t                      res
);
    import sacc_pkg::*;

    logic [NUM_WAYS-1:0] tag_eq;
    logic [NUM_WAYS-1:0] page_eq;
    logic [NUM_WAYS-1:0] dirty_nz;

    always_comb
    begin
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            tag_eq[w]   = valid[w] && (entry.tag[w] == address[ADDR_W-1:TAG_LSB]);
            dirty_nz[w] = |entry.dirty[w];
            page_eq[w]  = ((page_size == PS_4K) &&
                           (entry.tag[w][TAG_W-1:2] == address[ADDR_W-1:TAG_LSB+2])) ||
                          ((page_size == PS_8K) &&
                           (entry.tag[w][TAG_W-1:3] == address[ADDR_W-1:TAG_LSB+3]));
        end
    end

    always_comb
    begin
        res = '0;
        res.victim = counter;
        // scan downward so the lowest matching way wins
        for (int w = NUM_WAYS - 1; w >= 0; w--)
        begin
            if (tag_eq[w])
            begin
                res.hit       = 1'b1;
                res.hit_way   = WAY_W'(w);
                res.hit_dirty = entry.dirty[w];
            end
            if (!valid[w])
            begin
                res.victim = WAY_W'(w);
            end
        end
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            res.drop_mask[w] = valid[w] && (whole || page_eq[w]);
            res.drop_count   = res.drop_count + {2'b00, res.drop_mask[w]};
            res.dirty_count  = res.dirty_count + {2'b00, res.drop_mask[w] && dirty_nz[w]};
        end
    end

endmodule

// ===== src/sacc_cfg.sv =====
// APB register slave holding the dirty-state enable bit.
// Depends on sacc_pkg for the bus widths.
module sacc_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sacc_pkg::PADDR_W-1:0]  paddr,
    input  logic [sacc_pkg::PDATA_W-1:0]  pwdata,
    output logic [sacc_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output logic                          dirty_state_enable
);
    import sacc_pkg::*;

    logic dse_reg;
    logic dse_next;
    logic sel_dse;

    // only register 0 exists; the byte offset within the word is ignored
    assign sel_dse = (paddr[PADDR_W-1] == 1'b0);
    assign pready  = 1'b1;

    always_comb
    begin
        dse_next = dse_reg;
        if (psel && penable && pwrite && sel_dse)
        begin
            dse_next = pwdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dse_reg <= 1'b1;
        end
        else
        begin
            dse_reg <= dse_next;
        end
    end

    assign prdata             = sel_dse ? {{(PDATA_W-1){1'b0}}, dse_reg} : '0;
    assign dirty_state_enable = dse_reg;

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// Testbench for set_assoc_cache_tag_controller: a directed table followed by
// random requests, each result checked against a predictor of the tag store or a fixed table result.
// Depends on sacc_pkg and the block's RTL.
module tb;
    import sacc_pkg::*;

    localparam logic [PADDR_W-1:0] REG_DIRTY_EN = 3'd0;
    localparam logic [3:0] OP_UNUSED_LO = 4'd10;
    localparam logic [3:0] OP_UNUSED_HI = 4'd15;
    localparam logic [1:0] PS_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 500_000;
    localparam int PHASE_ITEMS = 200;

    typedef struct packed {
        logic [3:0]                opcode;
        logic [ADDR_W-1:0]         addr;
        logic [WAY_W-1:0]          way;
        logic [LONGS_PER_LINE-1:0] fmask;
        logic [1:0]                psize;
    } cache_req_t;

    typedef struct packed {
        logic                      hit;
        logic [WAY_W-1:0]          hit_way;
        logic [WAY_W-1:0]          victim_way;
        logic [1:0]                line_state;
        logic [LONGS_PER_LINE-1:0] wb_mask;
        logic [CNT_W-1:0]          touched;
        logic [CNT_W-1:0]          dirty;
    } cache_res_t;

    localparam cache_res_t NO_RESULT = '0;

    logic clk;
    logic rst_n;
    logic psel, penable, pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic pready;
    logic in_valid, in_stall;
    logic [3:0] opcode;
    logic [ADDR_W-1:0] address;
    logic [WAY_W-1:0] way;
    logic [LONGS_PER_LINE-1:0] fill_dirty_mask;
    logic [1:0] page_size;
    logic out_valid, out_stall;
    logic hit;
    logic [WAY_W-1:0] hit_way, victim_way;
    logic [1:0] line_state;
    logic [LONGS_PER_LINE-1:0] writeback_mask;
    logic [CNT_W-1:0] lines_touched, dirty_dropped;

    // predicted contents of the tag store
    logic [TAG_W-1:0]          tag_mem   [NUM_SETS][NUM_WAYS];
    logic                      valid_mem [NUM_SETS][NUM_WAYS];
    logic [LONGS_PER_LINE-1:0] dirty_mem [NUM_SETS][NUM_WAYS];
    logic [1:0]                repl_cnt;
    logic                      dirty_en;

    cache_res_t expected_results[$];
    logic [ADDR_W-1:0] filled_addrs[$];
    int errors;
    int cycles;
    logic calm;

    set_assoc_cache_tag_controller dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_stall(in_stall),
        .opcode(opcode), .address(address), .way(way),
        .fill_dirty_mask(fill_dirty_mask), .page_size(page_size),
        .out_valid(out_valid), .out_stall(out_stall),
        .hit(hit), .hit_way(hit_way), .victim_way(victim_way),
        .line_state(line_state), .writeback_mask(writeback_mask),
        .lines_touched(lines_touched), .dirty_dropped(dirty_dropped)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        out_stall <= calm ? 1'b0 : ($urandom_range(99) < 8);
    end

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH at cycle %0d: %s got %0d want %0d", cycles, what, got, want);
        errors++;
    endtask

    // Apply one request to the predicted state and return its result.
    function automatic cache_res_t cache_op_result(cache_req_t r);
        cache_res_t res;
        int s;
        int hw;
        int vw;
        logic [TAG_W-1:0] t;
        logic [ADDR_W-1:0] pbytes, keep, base, la;
        bit whole;
        res = '0;
        s = int'(r.addr[SET_LSB +: SET_W]);
        t = r.addr[ADDR_W-1:TAG_LSB];
        hw = NUM_WAYS;
        for (int w = NUM_WAYS - 1; w >= 0; w--)
            if (valid_mem[s][w] && tag_mem[s][w] == t)
                hw = w;
        case (r.opcode)
            OP_PROBE:
            begin
                if (hw < NUM_WAYS)
                begin
                    res.hit = 1'b1;
                    res.hit_way = hw[WAY_W-1:0];
                    res.line_state = (dirty_mem[s][hw] != 0) ? LS_DIRTY : LS_CLEAN;
                end
                vw = NUM_WAYS;
                for (int w = NUM_WAYS - 1; w >= 0; w--)
                    if (!valid_mem[s][w])
                        vw = w;
                res.victim_way = (vw < NUM_WAYS) ? vw[WAY_W-1:0] : repl_cnt;
            end
            OP_TICK:
                repl_cnt = repl_cnt + 2'd1;
            OP_FILL:
            begin
                tag_mem[s][r.way] = t;
                valid_mem[s][r.way] = 1'b1;
                dirty_mem[s][r.way] = dirty_en ? r.fmask : '0;
            end
            OP_MARK_DIRTY:
                if (dirty_en)
                    dirty_mem[s][r.way][r.addr[LONG_LSB +: 2]] = 1'b1;
            OP_INV_LINE, OP_PUSH_LINE:
                if (hw < NUM_WAYS)
                begin
                    if (r.opcode == OP_PUSH_LINE)
                        res.wb_mask = dirty_mem[s][hw];
                    valid_mem[s][hw] = 1'b0;
                    dirty_mem[s][hw] = '0;
                    res.touched = CNT_W'(1);
                end
            OP_INV_PAGE, OP_PUSH_PAGE, OP_INV_ALL, OP_PUSH_ALL:
            begin
                whole = (r.opcode == OP_INV_ALL || r.opcode == OP_PUSH_ALL);
                pbytes = (r.psize == PS_4K) ? 32'd4096 : (r.psize == PS_8K) ? 32'd8192 : '0;
                keep = ~(pbytes - 1);
                base = r.addr & keep;
                if (whole || pbytes != 0)
                begin
                    for (int si = 0; si < NUM_SETS; si++)
                        for (int w = 0; w < NUM_WAYS; w++)
                        begin
                            la = {tag_mem[si][w], 6'(si), 4'b0};
                            if (valid_mem[si][w] && (whole || (la & keep) == base))
                            begin
                                if (dirty_mem[si][w] != 0)
                                    res.dirty++;
                                valid_mem[si][w] = 1'b0;
                                dirty_mem[si][w] = '0;
                                res.touched++;
                            end
                        end
                end
                if (r.opcode == OP_INV_PAGE || r.opcode == OP_INV_ALL)
                    res.dirty = '0;
            end
            default:
                ;
        endcase
        return res;
    endfunction

    always @(posedge clk)
    begin
        cache_res_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
                report_mismatch("result with none pending", 0, 0);
            else
            begin
                want = expected_results.pop_front();
                if (hit !== want.hit)
                    report_mismatch("hit", hit, want.hit);
                if (hit_way !== want.hit_way)
                    report_mismatch("hit_way", hit_way, want.hit_way);
                if (victim_way !== want.victim_way)
                    report_mismatch("victim_way", victim_way, want.victim_way);
                if (line_state !== want.line_state)
                    report_mismatch("line_state", line_state, want.line_state);
                if (writeback_mask !== want.wb_mask)
                    report_mismatch("writeback_mask", writeback_mask, want.wb_mask);
                if (lines_touched !== want.touched)
                    report_mismatch("lines_touched", lines_touched, want.touched);
                if (dirty_dropped !== want.dirty)
                    report_mismatch("dirty_dropped", dirty_dropped, want.dirty);
            end
        end
    end

    // Hold the request until taken, then record its expected result.
    task automatic issue_request(cache_req_t r, bit fixed, cache_res_t fixed_res);
        int gap;
        cache_res_t res;
        gap = 0;
        if (!calm && $urandom_range(99) < 8)
            gap = $urandom_range(1, 3);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode <= r.opcode;
        address <= r.addr;
        way <= r.way;
        fill_dirty_mask <= r.fmask;
        page_size <= r.psize;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        res = cache_op_result(r);
        expected_results.push_back(fixed ? fixed_res : res);
    endtask

    // Write the register and read it back; only called while idle.
    task automatic set_dirty_enable(logic v);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= REG_DIRTY_EN;
        pwdata <= {31'b0, v};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        dirty_en = v;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== {31'b0, v})
            report_mismatch("dirty_state_enable readback", prdata, v);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    // Mostly reuse recent lines and low tags so probes hit and pages match.
    function automatic logic [ADDR_W-1:0] pick_address();
        logic [TAG_W-1:0] t;
        logic [SET_W-1:0] s;
        if (filled_addrs.size() != 0 && $urandom_range(99) < 60)
            return {filled_addrs[$urandom_range(filled_addrs.size() - 1)][ADDR_W-1:4],
                    4'($urandom)};
        t = ($urandom_range(3) == 0) ? TAG_W'($urandom) : TAG_W'($urandom_range(15));
        s = ($urandom_range(3) == 0) ? SET_W'($urandom) : SET_W'($urandom_range(7));
        return {t, s, 4'($urandom)};
    endfunction

    function automatic cache_req_t random_request();
        cache_req_t r;
        int pick;
        pick = $urandom_range(99);
        r.addr = pick_address();
        r.way = WAY_W'($urandom);
        r.fmask = LONGS_PER_LINE'($urandom);
        r.psize = ($urandom_range(4) == 0) ? 2'($urandom) : 2'($urandom_range(1, 2));
        if (pick < 25)
            r.opcode = OP_FILL;
        else if (pick < 50)
            r.opcode = OP_PROBE;
        else if (pick < 62)
            r.opcode = OP_MARK_DIRTY;
        else if (pick < 68)
            r.opcode = OP_TICK;
        else if (pick < 76)
            r.opcode = OP_INV_LINE;
        else if (pick < 85)
            r.opcode = OP_PUSH_LINE;
        else if (pick < 90)
            r.opcode = OP_INV_PAGE;
        else if (pick < 95)
            r.opcode = OP_PUSH_PAGE;
        else if (pick < 96)
            r.opcode = OP_INV_ALL;
        else if (pick < 98)
            r.opcode = OP_PUSH_ALL;
        else
            r.opcode = 4'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
        if (r.opcode == OP_FILL)
        begin
            filled_addrs.push_back(r.addr);
            if (filled_addrs.size() > 32)
                void'(filled_addrs.pop_front());
        end
        return r;
    endfunction

    cache_req_t dir_req[$];
    bit         dir_fixed[$];
    cache_res_t dir_res[$];

    function automatic void add_row(logic [3:0] op, logic [ADDR_W-1:0] a, logic [WAY_W-1:0] w,
                                    logic [3:0] m, logic [1:0] ps, bit fixed, cache_res_t res);
        dir_req.push_back('{op, a, w, m, ps});
        dir_fixed.push_back(fixed);
        dir_res.push_back(res);
    endfunction

    initial
    begin
        logic [1:0] enables [4];
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        opcode = OP_PROBE;
        address = '0;
        way = '0;
        fill_dirty_mask = '0;
        page_size = PS_NONE;
        out_stall = 1'b0;
        calm = 1'b0;
        errors = 0;
        cycles = 0;
        for (int s = 0; s < NUM_SETS; s++)
            for (int w = 0; w < NUM_WAYS; w++)
            begin
                tag_mem[s][w] = '0;
                valid_mem[s][w] = 1'b0;
                dirty_mem[s][w] = '0;
            end
        repl_cnt = '0;
        dirty_en = 1'b1;

        // empty cache, unused codes, top tag and set
        add_row(OP_PROBE, 32'h0, 2'd0, 4'h0, PS_NONE, 1, NO_RESULT);
        add_row(OP_PUSH_ALL, 32'h0, 2'd0, 4'h0, PS_NONE, 1, NO_RESULT);
        add_row(OP_UNUSED_HI, 32'hFFFF_FFFF, 2'd3, 4'hF, PS_UNUSED, 1, NO_RESULT);
        add_row(OP_UNUSED_LO, 32'h0, 2'd0, 4'h0, PS_NONE, 1, NO_RESULT);
        add_row(OP_TICK, 32'h0, 2'd0, 4'h0, PS_NONE, 1, NO_RESULT);
        add_row(OP_FILL, 32'hFFFF_FFF0, 2'd3, 4'hF, PS_NONE, 0, NO_RESULT);
        add_row(OP_PROBE, 32'hFFFF_FFFC, 2'd0, 4'h0, PS_NONE, 1,
                '{1'b1, 2'd3, 2'd0, LS_DIRTY, 4'h0, 9'd0, 9'd0});
        add_row(OP_FILL, 32'h0, 2'd0, 4'h0, PS_NONE, 0, NO_RESULT);
        add_row(OP_PROBE, 32'h8, 2'd0, 4'h0, PS_NONE, 0, NO_RESULT);
        add_row(OP_MARK_DIRTY, 32'hC, 2'd0, 4'h0, PS_NONE, 0, NO_RESULT);
        add_row(OP_PUSH_LINE, 32'h0, 2'd0, 4'h0, PS_NONE, 0, NO_RESULT);
        // line operation that misses
        add_row(OP_PUSH_LINE, 32'h0, 2'd0, 4'h0, PS_NONE, 1, NO_RESULT);
        // mark dirty on an invalid line, then a clean fill over it
        add_row(OP_MARK_DIRTY, 32'h4, 2'd1, 4'h0, PS_NONE, 0, NO_RESULT);
        add_row(OP_FILL, 32'h0, 2'd1, 4'h0, PS_NONE, 0, NO_RESULT);
        add_row(OP_PROBE, 32'h0, 2'd0, 4'h0, PS_NONE, 0, NO_RESULT);
        add_row(OP_FILL, 32'h0000_1010, 2'd2, 4'h1, PS_NONE, 0, NO_RESULT);
        // page size none and unused page code touch nothing
        add_row(OP_INV_PAGE, 32'h0000_1000, 2'd0, 4'h0, PS_NONE, 1, NO_RESULT);
        add_row(OP_PUSH_PAGE, 32'h0000_1000, 2'd0, 4'h0, PS_UNUSED, 1, NO_RESULT);
        add_row(OP_PUSH_PAGE, 32'h0000_1FFF, 2'd0, 4'h0, PS_4K, 0, NO_RESULT);
        // full set: victim falls back to the counter
        add_row(OP_FILL, 32'h0000_0050, 2'd0, 4'h3, PS_NONE, 0, NO_RESULT);
        add_row(OP_FILL, 32'h0000_0450, 2'd1, 4'h0, PS_NONE, 0, NO_RESULT);
        add_row(OP_FILL, 32'h0000_0850, 2'd2, 4'h8, PS_NONE, 0, NO_RESULT);
        add_row(OP_FILL, 32'h0000_0C50, 2'd3, 4'h0, PS_NONE, 0, NO_RESULT);
        add_row(OP_PROBE, 32'h0000_1050, 2'd0, 4'h0, PS_NONE, 0, NO_RESULT);
        add_row(OP_INV_LINE, 32'h0000_0450, 2'd0, 4'h0, PS_NONE, 0, NO_RESULT);
        add_row(OP_PUSH_PAGE, 32'h0000_1234, 2'd0, 4'h0, PS_8K, 0, NO_RESULT);
        add_row(OP_INV_ALL, 32'h0, 2'd0, 4'h0, PS_NONE, 0, NO_RESULT);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < dir_req.size(); i++)
            issue_request(dir_req[i], dir_fixed[i], dir_res[i]);
        drain();

        // alternate the setting so stored dirty bits survive a change to 0
        enables = '{2'd0, 2'd1, 2'd0, 2'd1};
        for (int ph = 0; ph < 4; ph++)
        begin
            set_dirty_enable(enables[ph][0]);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (ph == 1 && i == 50)
                    calm <= 1'b1;
                if (ph == 1 && i == 150)
                    calm <= 1'b0;
                issue_request(random_request(), 0, NO_RESULT);
            end
            drain();
        end

        repeat (70) @(posedge clk);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
